/* hdl/hep_pkg.sv */
// ----------------------------------------------------------------------------
// hep_pkg
// Types and constants shared by the hash entropy pool and its interfaces.
// ----------------------------------------------------------------------------
package hep_pkg;

    localparam int unsigned ABSORB_MAX = 64;

    localparam logic [31:0] EXPORT_TAG = 32'h5053_5058;

    localparam logic [31:0] IV0 = 32'h6745_2301;
    localparam logic [31:0] IV1 = 32'hEFCD_AB89;
    localparam logic [31:0] IV2 = 32'h98BA_DCFE;
    localparam logic [31:0] IV3 = 32'h1032_5476;
    localparam logic [31:0] IV4 = 32'hC3D2_E1F0;

    localparam logic [31:0] K0 = 32'h5A82_7999;
    localparam logic [31:0] K1 = 32'h6ED9_EBA1;
    localparam logic [31:0] K2 = 32'h8F1B_BCDC;
    localparam logic [31:0] K3 = 32'hCA62_C1D6;

    typedef enum logic [1:0] {
        OP_ABSORB   = 2'd0,
        OP_GENERATE = 2'd1,
        OP_EXPORT   = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
        logic       data_last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        word_last;
    } t_out_item;

endpackage

/* hdl/hep_in_if.sv */
// ----------------------------------------------------------------------------
// hep_in_if
// Valid/ready channel carrying one operation item per transfer.
// ----------------------------------------------------------------------------
interface hep_in_if;
    logic              valid;
    logic              ready;
    hep_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/hep_out_if.sv */
// ----------------------------------------------------------------------------
// hep_out_if
// Valid/ready channel carrying one digest word per transfer.
// ----------------------------------------------------------------------------
interface hep_out_if;
    logic               valid;
    logic               ready;
    hep_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/hash_entropy_pool_top.sv */
// ----------------------------------------------------------------------------
// hash_entropy_pool_top
// SHA-1 entropy pool with absorb, generate, export and clear operations.
// ----------------------------------------------------------------------------
// One SHA-1 round unit is shared by every hash. Each message block is first
// shifted in one byte per cycle (the absorb buffer is read through its
// registered port), then runs 80 rounds and a chaining step. An absorb byte
// without the last flag is only stored; a last byte hashes one block, or two
// when more than 35 bytes were collected. Generate hashes twice and then
// offers five words; export hashes once and then offers five words. Clear
// zeroes the pool without hashing. The input is not ready while a hash runs
// or words are still waiting.
module hash_entropy_pool_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hep_in_if.sink          i_in,
    hep_out_if.source       o_out
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_ROUND = 5'b00100,
        S_FINAL = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    typedef enum logic [3:0] {
        PH_ABS  = 4'b0001,
        PH_GEN1 = 4'b0010,
        PH_GEN2 = 4'b0100,
        PH_EXP  = 4'b1000
    } t_phase;

    t_state       r_state;
    t_phase       r_phase;
    logic [31:0]  r_pool [5];
    logic [31:0]  r_counter;
    logic [7:0]   r_buf  [64];
    logic [6:0]   r_count;
    logic [6:0]   r_len;
    logic [7:0]   r_rd;
    logic [31:0]  r_h    [5];
    logic [31:0]  r_dig  [5];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [511:0] r_wv;
    logic [6:0]   r_lp;
    logic [6:0]   r_qpos;
    logic         r_blk;
    logic [6:0]   r_rnd;
    logic [2:0]   r_idx;

    logic         in_acc;
    logic [6:0]   n_count;
    logic [6:0]   issue_pos;
    logic [6:0]   rd_addr;
    logic [6:0]   total;
    logic         two_blocks;
    logic [9:0]   msg_bits;
    logic [6:0]   ext_pos;
    logic [31:0]  ext_word;
    logic [31:0]  pool_word;
    logic [31:0]  dig_word;
    logic [7:0]   ld_byte;
    logic [31:0]  f_val, k_val, t_val, w_new;
    logic [31:0]  n_h [5];
    logic         last_blk_done;

    assign in_acc  = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign o_out.valid               = (r_state == S_EMIT);
    assign o_out.payload.digest_word = r_dig[r_idx];
    assign o_out.payload.word_last   = (r_idx == 3'd4);

    assign n_count = (r_count < 7'(hep_pkg::ABSORB_MAX)) ? r_count + 7'd1 : r_count;

    assign issue_pos = {r_blk, r_lp[5:0]};
    assign rd_addr   = issue_pos - 7'd20;

    assign total      = r_len + 7'd20;
    assign two_blocks = (total >= 7'd56);
    assign msg_bits   = {total, 3'b000};
    assign ext_pos    = r_qpos - 7'd20;
    assign ext_word   = (r_phase == PH_EXP) ? hep_pkg::EXPORT_TAG : r_counter;
    assign pool_word  = r_pool[r_qpos[4:2]] >> {~r_qpos[1:0], 3'b000};
    assign dig_word   = r_dig[ext_pos[4:2]] >> {~ext_pos[1:0], 3'b000};

    always_comb begin
        if (r_qpos < 7'd20) begin
            ld_byte = pool_word[7:0];
        end else if (r_qpos < total) begin
            priority case (1'b1)
                (r_phase == PH_ABS):  ld_byte = r_rd;
                (r_phase == PH_GEN2): ld_byte = dig_word[7:0];
                default:              ld_byte = ext_word[{ext_pos[1:0], 3'b000} +: 8];
            endcase
        end else if (r_qpos == total) begin
            ld_byte = 8'h80;
        end else if ((r_qpos[6] == two_blocks) && (r_qpos[5:0] == 6'd62)) begin
            ld_byte = {6'd0, msg_bits[9:8]};
        end else if ((r_qpos[6] == two_blocks) && (r_qpos[5:0] == 6'd63)) begin
            ld_byte = msg_bits[7:0];
        end else begin
            ld_byte = 8'h00;
        end
    end

    always_comb begin
        if (r_rnd < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = hep_pkg::K0;
        end else if (r_rnd < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = hep_pkg::K1;
        end else if (r_rnd < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = hep_pkg::K2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = hep_pkg::K3;
        end
        t_val = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + r_wv[511:480];
        w_new = r_wv[95:64] ^ r_wv[255:224] ^ r_wv[447:416] ^ r_wv[511:480];
        w_new = {w_new[30:0], w_new[31]};
    end

    assign n_h[0] = r_h[0] + r_a;
    assign n_h[1] = r_h[1] + r_b;
    assign n_h[2] = r_h[2] + r_c;
    assign n_h[3] = r_h[3] + r_d;
    assign n_h[4] = r_h[4] + r_e;
    assign last_blk_done = (r_blk == two_blocks);

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in.payload.operation == hep_pkg::OP_ABSORB) &&
            (r_count < 7'(hep_pkg::ABSORB_MAX))) begin
            r_buf[r_count[5:0]] <= i_in.payload.data_byte;
        end
        r_rd <= r_buf[rd_addr[5:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_ABS;
            r_count   <= 7'd0;
            r_counter <= 32'd0;
            r_idx     <= 3'd0;
            for (int i = 0; i < 5; i++) begin
                r_pool[i] <= 32'd0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_lp  <= 7'd0;
                    r_blk <= 1'b0;
                    r_h[0] <= hep_pkg::IV0;
                    r_h[1] <= hep_pkg::IV1;
                    r_h[2] <= hep_pkg::IV2;
                    r_h[3] <= hep_pkg::IV3;
                    r_h[4] <= hep_pkg::IV4;
                    if (in_acc) begin
                        unique case (i_in.payload.operation)
                            hep_pkg::OP_ABSORB: begin
                                r_count <= n_count;
                                r_len   <= n_count;
                                r_phase <= PH_ABS;
                                if (i_in.payload.data_last) begin
                                    r_state <= S_LOAD;
                                end
                            end
                            hep_pkg::OP_GENERATE: begin
                                r_len   <= 7'd4;
                                r_phase <= PH_GEN1;
                                r_state <= S_LOAD;
                            end
                            hep_pkg::OP_EXPORT: begin
                                r_len   <= 7'd4;
                                r_phase <= PH_EXP;
                                r_state <= S_LOAD;
                            end
                            default: begin
                                for (int i = 0; i < 5; i++) begin
                                    r_pool[i] <= 32'd0;
                                end
                            end
                        endcase
                    end
                end
                S_LOAD: begin
                    r_lp   <= r_lp + 7'd1;
                    r_qpos <= issue_pos;
                    if (r_lp != 7'd0) begin
                        r_wv <= {r_wv[503:0], ld_byte};
                    end
                    if (r_lp == 7'd64) begin
                        r_a     <= r_h[0];
                        r_b     <= r_h[1];
                        r_c     <= r_h[2];
                        r_d     <= r_h[3];
                        r_e     <= r_h[4];
                        r_rnd   <= 7'd0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_e   <= r_d;
                    r_d   <= r_c;
                    r_c   <= {r_b[1:0], r_b[31:2]};
                    r_b   <= r_a;
                    r_a   <= t_val;
                    r_wv  <= {r_wv[479:0], w_new};
                    r_rnd <= r_rnd + 7'd1;
                    if (r_rnd == 7'd79) begin
                        r_state <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    r_lp <= 7'd0;
                    for (int i = 0; i < 5; i++) begin
                        r_h[i] <= n_h[i];
                    end
                    if (!last_blk_done) begin
                        r_blk   <= 1'b1;
                        r_state <= S_LOAD;
                    end else begin
                        r_blk <= 1'b0;
                        unique case (r_phase)
                            PH_ABS: begin
                                for (int i = 0; i < 5; i++) begin
                                    r_pool[i] <= n_h[i];
                                end
                                r_count <= 7'd0;
                                r_state <= S_IDLE;
                            end
                            PH_GEN1: begin
                                for (int i = 0; i < 5; i++) begin
                                    r_dig[i] <= n_h[i];
                                end
                                r_h[0]    <= hep_pkg::IV0;
                                r_h[1]    <= hep_pkg::IV1;
                                r_h[2]    <= hep_pkg::IV2;
                                r_h[3]    <= hep_pkg::IV3;
                                r_h[4]    <= hep_pkg::IV4;
                                r_counter <= r_counter + 32'd1;
                                r_len     <= 7'd20;
                                r_phase   <= PH_GEN2;
                                r_state   <= S_LOAD;
                            end
                            PH_GEN2: begin
                                for (int i = 0; i < 5; i++) begin
                                    r_pool[i] <= n_h[i];
                                end
                                r_idx   <= 3'd0;
                                r_state <= S_EMIT;
                            end
                            default: begin
                                for (int i = 0; i < 5; i++) begin
                                    r_dig[i] <= n_h[i];
                                end
                                r_idx   <= 3'd0;
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                default: begin
                    if (o_out.ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd4) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
            endcase
        end
    end

endmodule

/* test/tb_hash_entropy_pool_top.sv */
// ----------------------------------------------------------------------------
// tb_hash_entropy_pool_top
// Drives absorb, generate, export and clear operations into the entropy pool
// with random gaps and output stalls. A behavioural SHA-1 pool predicts every
// digest word, which is compared field by field with the words that leave.
// ----------------------------------------------------------------------------
module tb_hash_entropy_pool_top;
    import hep_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hep_in_if  in_ch();
    hep_out_if out_ch();

    hash_entropy_pool_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    t_in_item  pending_ops[$];
    t_out_item digest_queue[$];

    logic [31:0] pool_state [5];
    logic [31:0] gen_counter;
    logic [7:0]  absorb_bytes [64];
    int unsigned absorb_len;

    int  errors = 0;
    bit  steady = 1'b0;

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // SHA-1 over the pool bytes followed by len extra bytes.
    task automatic sha1_pool(input logic [7:0] extra [64], input int unsigned len,
                             output logic [31:0] h [5]);
        logic [7:0]  msg [128];
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        logic [63:0] bits;
        int unsigned total, blocks;
        for (int i = 0; i < 128; i++) msg[i] = 8'h00;
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 4; j++) msg[4*i+j] = pool_state[i][31-8*j -: 8];
        for (int i = 0; i < len; i++) msg[20+i] = extra[i];
        total = 20 + len;
        msg[total] = 8'h80;
        blocks = (total + 8) / 64 + 1;
        bits = 64'(total) * 8;
        for (int i = 0; i < 8; i++) msg[blocks*64-1-i] = bits[8*i +: 8];
        h[0] = IV0; h[1] = IV1; h[2] = IV2; h[3] = IV3; h[4] = IV4;
        for (int blk = 0; blk < blocks; blk++) begin
            for (int i = 0; i < 16; i++)
                w[i] = {msg[64*blk+4*i], msg[64*blk+4*i+1],
                        msg[64*blk+4*i+2], msg[64*blk+4*i+3]};
            for (int i = 16; i < 80; i++)
                w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
            a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
            for (int i = 0; i < 80; i++) begin
                if (i < 20) begin
                    f = (b & c) | (~b & d); k = K0;
                end else if (i < 40) begin
                    f = b ^ c ^ d; k = K1;
                end else if (i < 60) begin
                    f = (b & c) | (b & d) | (c & d); k = K2;
                end else begin
                    f = b ^ c ^ d; k = K3;
                end
                t = rol(a, 5) + f + e + k + w[i];
                e = d; d = c; c = rol(b, 30); b = a; a = t;
            end
            h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
        end
    endtask

    task automatic push_digest(input logic [31:0] h [5]);
        for (int i = 0; i < 5; i++) digest_queue.push_back({h[i], 1'(i == 4)});
    endtask

    task automatic predict_pool(input t_in_item it);
        logic [7:0]  extra [64];
        logic [31:0] h [5];
        logic [31:0] nh [5];
        for (int i = 0; i < 64; i++) extra[i] = 8'h00;
        case (t_op'(it.operation))
            OP_ABSORB: begin
                if (absorb_len < ABSORB_MAX) begin
                    absorb_bytes[absorb_len] = it.data_byte;
                    absorb_len++;
                end
                if (it.data_last) begin
                    sha1_pool(absorb_bytes, absorb_len, h);
                    pool_state = h;
                    absorb_len = 0;
                end
            end
            OP_GENERATE: begin
                for (int i = 0; i < 4; i++) extra[i] = gen_counter[8*i +: 8];
                sha1_pool(extra, 4, h);
                gen_counter++;
                for (int i = 0; i < 5; i++)
                    for (int j = 0; j < 4; j++) extra[4*i+j] = h[i][31-8*j -: 8];
                sha1_pool(extra, 20, nh);
                pool_state = nh;
                push_digest(h);
            end
            OP_EXPORT: begin
                for (int i = 0; i < 4; i++) extra[i] = EXPORT_TAG[8*i +: 8];
                sha1_pool(extra, 4, h);
                push_digest(h);
            end
            default: begin
                for (int i = 0; i < 5; i++) pool_state[i] = 32'h0;
            end
        endcase
    endtask

    function automatic bit idle_now();
        return !steady && ($urandom_range(99) < 36);
    endfunction

    // Driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (pending_ops.size() > 0 && !idle_now()) begin
                in_ch.payload <= pending_ops.pop_front();
                in_ch.valid   <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Prediction on accepted transfers, checking and output stalls.
    always @(posedge i_clk) begin
        t_out_item exp_w;
        if (i_rst_n && in_ch.valid && in_ch.ready) predict_pool(in_ch.payload);
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (digest_queue.size() == 0) begin
                $display("%0t unexpected word: actual %h/%b", $time,
                         out_ch.payload.digest_word, out_ch.payload.word_last);
                errors++;
            end else begin
                exp_w = digest_queue.pop_front();
                if (exp_w.digest_word !== out_ch.payload.digest_word) begin
                    $display("%0t digest_word: expected %h actual %h", $time,
                             exp_w.digest_word, out_ch.payload.digest_word);
                    errors++;
                end
                if (exp_w.word_last !== out_ch.payload.word_last) begin
                    $display("%0t word_last: expected %b actual %b", $time,
                             exp_w.word_last, out_ch.payload.word_last);
                    errors++;
                end
            end
        end
        out_ch.ready <= i_rst_n && !idle_now();
    end

    task automatic add_op(input t_op op, input logic [7:0] b, input logic l);
        pending_ops.push_back({op, b, l});
    endtask

    task automatic add_message(input int unsigned n);
        for (int i = 0; i < n; i++)
            add_op(OP_ABSORB, 8'($urandom), 1'(i == n - 1));
    endtask

    initial begin
        int unsigned r;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < 5; i++) pool_state[i] = 32'h0;
        gen_counter = 32'h0;
        absorb_len = 0;
        for (int i = 0; i < 64; i++) absorb_bytes[i] = 8'h00;

        // Directed: operations on the empty pool, extreme bytes, a one-byte
        // message, clear in the middle of a message, then an overlong one.
        add_op(OP_EXPORT, 8'hFF, 1'b1);
        add_op(OP_GENERATE, 8'h00, 1'b0);
        add_op(OP_ABSORB, 8'hFF, 1'b1);
        add_op(OP_ABSORB, 8'h00, 1'b0);
        add_op(OP_CLEAR, 8'hAA, 1'b1);
        add_op(OP_ABSORB, 8'h55, 1'b1);
        add_op(OP_EXPORT, 8'h00, 1'b0);
        add_op(OP_CLEAR, 8'h00, 1'b0);
        add_op(OP_GENERATE, 8'hFF, 1'b1);
        add_message(36);
        add_op(OP_GENERATE, 8'h00, 1'b0);
        add_message(70);
        add_op(OP_EXPORT, 8'h00, 1'b0);

        // Random: whole messages of random length, mixed with the
        // other operations and stray bytes.
        for (int n = 0; n < 300; ) begin
            r = $urandom_range(99);
            if (r < 40) begin
                r = ($urandom_range(9) == 0) ? $urandom_range(80, 36)
                                              : $urandom_range(12, 1);
                add_message(r);
                n += r;
            end else if (r < 65) begin
                add_op(OP_GENERATE, 8'($urandom), 1'($urandom));
                n++;
            end else if (r < 85) begin
                add_op(OP_EXPORT, 8'($urandom), 1'($urandom));
                n++;
            end else if (r < 93) begin
                add_op(OP_CLEAR, 8'($urandom), 1'($urandom));
                n++;
            end else begin
                add_op(OP_ABSORB, 8'($urandom), 1'($urandom));
                n++;
            end
        end
        add_message(3);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (400) @(posedge i_clk);
        steady <= 1'b1;
        repeat (20000) @(posedge i_clk);
        steady <= 1'b0;

        while (pending_ops.size() > 0 || in_ch.valid) @(posedge i_clk);
        while (digest_queue.size() > 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (errors == 0 && digest_queue.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

/* files.f */
hdl/hep_pkg.sv
hdl/hep_in_if.sv
hdl/hep_out_if.sv
hdl/hash_entropy_pool_top.sv
test/tb_hash_entropy_pool_top.sv
